### src/upd_pkg.sv
// Package with shared types, character constants and helper functions for the URL decoder.
`timescale 1ns / 1ps

package upd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0]                   cnt;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
        logic                         last;
    } t_rec;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       open;
    } t_fresh;

    typedef struct packed {
        logic idle;
        logic accept;
        logic push;
    } t_front_stat;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.is_hex = 1'b0;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h57);
        end
        return h;
    endfunction

    function automatic t_fresh fresh_byte(input logic [7:0] b, input logic last);
        t_fresh f;
        f.emit = 1'b1;
        f.data = b;
        f.open = 1'b0;
        if (b == CH_PERCENT) begin
            f.emit = last;
            f.open = !last;
        end else if (b == CH_PLUS) begin
            f.data = CH_SPACE;
        end
        return f;
    endfunction

endpackage

### src/url_percent_decoder.sv
// Top level of the URL percent decoder: front end, record queue and output serializer.
//
// Input channel: i_valid / o_ready carry one encoded byte per beat (i_in_byte),
// with i_in_last on the final byte of a string. Output channel: o_valid /
// i_ready carry one decoded byte per beat (o_out_byte), with o_out_last on the
// final decoded byte of the string.
// The front end decodes one input beat per cycle while the queue has room and
// writes each nonempty result (up to 3 bytes) as one record into a 4-deep
// queue; the back end plays out one byte per cycle while the receiver is
// ready. Throughput is one input beat per cycle while each beat yields at most
// one byte; a broken escape can yield two or three bytes, one output beat each,
// which the queue absorbs until it fills.
// Reset clears the escape phase, the held digit and the queue; o_ready rises in
// the first cycle after reset. When the receiver stalls, the current output
// beat holds, the queue fills and o_ready drops once it is full.
`timescale 1ns / 1ps

module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic        push_valid, push_ready, pop_valid, pop;
    t_rec        push_rec, pop_rec;
    t_front_stat front_stat;

    upd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_rec   (push_rec),
        .o_stat       (front_stat)
    );

    upd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_rec   (push_rec),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_rec    (pop_rec)
    );

    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (pop_valid),
        .i_rec       (pop_rec),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

`ifndef ASSERT_OFF
    a_last_closes_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_stat.accept && i_in_last) |=> front_stat.idle)
        else $error("escape left open after final byte");

    a_push_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_stat.push |-> (front_stat.accept && push_ready))
        else $error("record pushed without an accepted beat");

    a_record_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid |-> (push_rec.cnt != 2'd0))
        else $error("empty record pushed");

    a_idle_back_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_valid && !o_valid) |=> o_valid)
        else $error("queued record not loaded");
`endif

endmodule

### src/upd_front.sv
// Front end: accepts input beats, tracks the escape phase and builds result records.
`timescale 1ns / 1ps

module upd_front
    import upd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_push_ready,
    output logic        o_push_valid,
    output t_rec        o_push_rec,
    output t_front_stat o_stat
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held,  n_held;
    t_rec       rec;
    t_hex       cur_hex, held_hex;
    t_fresh     fr;
    logic       accept;

    always_comb begin
        cur_hex  = hex_decode(i_in_byte);
        held_hex = hex_decode(r_held);
        fr       = fresh_byte(i_in_byte, i_in_last);
        rec      = '0;
        rec.last = i_in_last;
        n_phase  = r_phase;
        n_held   = r_held;
        case (r_phase)
            PH_PCT: begin
                if (cur_hex.is_hex) begin
                    if (i_in_last) begin
                        rec.cnt      = 2'd2;
                        rec.bytes[0] = CH_PERCENT;
                        rec.bytes[1] = i_in_byte;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_held  = i_in_byte;
                        n_phase = PH_DIGIT;
                    end
                end else begin
                    rec.cnt      = 2'd1 + {1'b0, fr.emit};
                    rec.bytes[0] = CH_PERCENT;
                    rec.bytes[1] = fr.data;
                    n_phase      = fr.open ? PH_PCT : PH_IDLE;
                end
            end
            PH_DIGIT: begin
                if (cur_hex.is_hex && held_hex.is_hex) begin
                    rec.cnt      = 2'd1;
                    rec.bytes[0] = {held_hex.value, cur_hex.value};
                    n_phase      = PH_IDLE;
                end else begin
                    rec.cnt      = 2'd2 + {1'b0, fr.emit};
                    rec.bytes[0] = CH_PERCENT;
                    rec.bytes[1] = r_held;
                    rec.bytes[2] = fr.data;
                    n_phase      = fr.open ? PH_PCT : PH_IDLE;
                end
            end
            default: begin
                rec.cnt      = {1'b0, fr.emit};
                rec.bytes[0] = fr.data;
                n_phase      = fr.open ? PH_PCT : PH_IDLE;
            end
        endcase
    end

    assign o_ready      = i_push_ready;
    assign accept       = i_valid && i_push_ready;
    assign o_push_valid = accept && (rec.cnt != 2'd0);
    assign o_push_rec   = rec;

    assign o_stat.idle   = (r_phase == PH_IDLE);
    assign o_stat.accept = accept;
    assign o_stat.push   = o_push_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

### src/upd_queue.sv
// Short record queue between the front end and the output serializer.
`timescale 1ns / 1ps

module upd_queue
    import upd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_rec i_push_rec,
    output logic o_pop_valid,
    input  logic i_pop,
    output t_rec o_pop_rec
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [AW:0]   r_level;
    logic          push, pop;

    assign o_push_ready = (r_level != (AW+1)'(DEPTH));
    assign o_pop_valid  = (r_level != '0);
    assign o_pop_rec    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({push, pop})
                2'b10:   r_level <= r_level + (AW+1)'(1);
                2'b01:   r_level <= r_level - (AW+1)'(1);
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

### src/upd_back.sv
// Back end: plays out each record as one to three output beats.
`timescale 1ns / 1ps

module upd_back
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rec_valid,
    input  t_rec       i_rec,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    t_rec       r_rec;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       final_beat, done, load;

    assign final_beat = (r_idx == r_rec.cnt - 2'd1);
    assign done       = r_busy && i_ready && final_beat;
    assign load       = i_rec_valid && (!r_busy || done);
    assign o_pop      = load;

    assign o_valid    = r_busy;
    assign o_out_byte = r_rec.bytes[r_idx];
    assign o_out_last = r_rec.last && final_beat;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (r_busy && i_ready) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

endmodule
